// File: design/lcg48_pkg.sv
// ----------------------------------------------------------------------------
// lcg48_pkg
// Shared constants, request codes and types of the 48-bit LCG random source.
// ----------------------------------------------------------------------------
package lcg48_pkg;

    localparam int STATE_BITS = 48;
    localparam int DRAW_BITS  = 31;
    localparam int FRAC_BITS  = 24;
    localparam int WORD_BITS  = 32;
    localparam int CHUNK_BITS = 16;
    localparam int MULT_BITS  = 35;
    localparam int CNT_BITS   = 6;

    localparam logic [MULT_BITS-1:0]  LCG_MULT = 35'h5DEECE66D;
    localparam logic [STATE_BITS-1:0] LCG_ADD  = 48'hB;

    localparam logic [2:0] MODE_TOP    = 3'd0;
    localparam logic [2:0] MODE_BOOL   = 3'd1;
    localparam logic [2:0] MODE_WORD   = 3'd2;
    localparam logic [2:0] MODE_BELOW  = 3'd3;
    localparam logic [2:0] MODE_RANGE  = 3'd4;
    localparam logic [2:0] MODE_FRAC   = 3'd5;
    localparam logic [2:0] MODE_RESEED = 3'd6;
    localparam logic [2:0] MODE_UNUSED = 3'd7;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

// File: design/lcg48_random_source.sv
// ----------------------------------------------------------------------------
// lcg48_random_source
// 48-bit linear congruential random source with bounded and range draws.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall with one port per request field. A
// transaction is taken when i_valid is high and o_stall is low. Output
// channel: o_valid / i_stall carrying o_value and o_bad_bound; every request
// gives exactly one result transaction.
// o_stall is high from the cycle after a request is taken until its result is
// loaded into the output register, so one request is worked on at a time.
// A state step runs on one shared 16 x 35 multiplier, one 16-bit chunk at a time.
// Plain draws pass from the multiply steps through S_POST to S_WRITE.
// Bounded draws run a 31-step serial remainder unit and a check state; each
// rejection starts another attempt with a fresh state step. Power of two
// bounds use one 31 x 31 product instead. Reseed, bad bounds and the unused
// mode go straight to the write state.
// A finished result waits in the output register while i_stall is high; the
// next request is taken meanwhile and its result waits for that slot.
// Synchronous reset clears the state to zero and empties the output.
// ----------------------------------------------------------------------------
module lcg48_random_source (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_mode,
    input  logic [5:0]         i_bit_count,
    input  logic signed [31:0] i_bound,
    input  logic signed [31:0] i_range_low,
    input  logic signed [31:0] i_range_high,
    input  logic [47:0]        i_seed_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_value,
    output logic               o_bad_bound
);

    localparam int SB = lcg48_pkg::STATE_BITS;
    localparam int DB = lcg48_pkg::DRAW_BITS;
    localparam int WB = lcg48_pkg::WORD_BITS;
    localparam int CB = lcg48_pkg::CHUNK_BITS;
    localparam int MB = lcg48_pkg::MULT_BITS;
    localparam int KB = lcg48_pkg::CNT_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_POST  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_CHK   = 3'd4;
    localparam logic [2:0] S_PMUL  = 3'd5;
    localparam logic [2:0] S_WRITE = 3'd6;

    logic [2:0]      r_st;
    logic [SB-1:0]   r_rng;
    logic [SB-1:0]   r_acc;
    logic [1:0]      r_mk;
    logic [2:0]      r_mode;
    logic [KB-1:0]   r_count;
    logic [DB-1:0]   r_n;
    logic [WB-1:0]   r_lo;
    logic            r_pow2;
    logic [DB-1:0]   r_bits;
    logic [2*DB-1:0] r_prod;
    logic [WB-1:0]   r_res;
    logic            r_res_bad;
    logic            r_out_valid;
    logic [WB-1:0]   r_out_value;
    logic            r_out_bad;

    logic [SB-1:0]      n_acc;
    logic [CB-1:0]      chunk;
    logic [CB+MB-1:0]   chunk_prod;
    logic [WB-1:0]      width;
    logic [WB-1:0]      nval;
    logic               bounded_in;
    logic               bad_in;
    logic               bounded;
    logic [WB-1:0]      chk;
    logic               div_start;
    logic               out_free;
    logic               load_out;
    lcg48_pkg::t_div_status div_st;
    logic [DB-1:0]      div_rem;

    always_comb begin
        case (r_mk)
            2'd0:    chunk = r_rng[CB-1:0];
            2'd1:    chunk = r_rng[2*CB-1:CB];
            default: chunk = r_rng[3*CB-1:2*CB];
        endcase
        chunk_prod = {{MB{1'b0}}, chunk} * {{CB{1'b0}}, lcg48_pkg::LCG_MULT};
        case (r_mk)
            2'd0:    n_acc = r_acc + SB'(chunk_prod);
            2'd1:    n_acc = r_acc + SB'({chunk_prod, {CB{1'b0}}});
            default: n_acc = r_acc + SB'({chunk_prod, {2*CB{1'b0}}});
        endcase
    end

    assign width      = $unsigned(i_range_high) - $unsigned(i_range_low);
    assign nval       = (i_mode == lcg48_pkg::MODE_BELOW) ? $unsigned(i_bound) : width;
    assign bounded_in = (i_mode == lcg48_pkg::MODE_BELOW) || (i_mode == lcg48_pkg::MODE_RANGE);
    assign bad_in     = bounded_in && ((nval == '0) || nval[WB-1]);
    assign bounded    = (r_mode == lcg48_pkg::MODE_BELOW) || (r_mode == lcg48_pkg::MODE_RANGE);
    assign chk        = {1'b0, r_bits} - {1'b0, div_rem} + {1'b0, r_n} - 32'd1;
    assign div_start  = (r_st == S_POST) && bounded && !r_pow2;
    assign out_free   = !r_out_valid || !i_stall;
    assign load_out   = (r_st == S_WRITE) && out_free;

    lcg48_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_rng[SB-1:SB-DB]),
        .i_divisor  (r_n),
        .o_status   (div_st),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_IDLE;
            r_rng <= '0;
        end else begin
            case (r_st)
                S_IDLE: begin
                    if (i_valid) begin
                        r_mode    <= i_mode;
                        r_count   <= (i_bit_count > 6'd32) ? 6'd32 : i_bit_count;
                        r_n       <= nval[DB-1:0];
                        r_pow2    <= (nval & (nval - 32'd1)) == '0;
                        r_lo      <= (i_mode == lcg48_pkg::MODE_RANGE) ?
                                     $unsigned(i_range_low) : '0;
                        r_res     <= '0;
                        r_res_bad <= bad_in;
                        r_acc     <= lcg48_pkg::LCG_ADD;
                        r_mk      <= 2'd0;
                        if (i_mode == lcg48_pkg::MODE_RESEED) begin
                            r_rng <= i_seed_value;
                            r_st  <= S_WRITE;
                        end else if (bad_in || (i_mode == lcg48_pkg::MODE_UNUSED)) begin
                            r_st <= S_WRITE;
                        end else begin
                            r_st <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_acc <= n_acc;
                    r_mk  <= r_mk + 2'd1;
                    if (r_mk == 2'd2) begin
                        r_rng <= n_acc;
                        r_st  <= S_POST;
                    end
                end
                S_POST: begin
                    r_bits <= r_rng[SB-1:SB-DB];
                    r_st   <= bounded ? (r_pow2 ? S_PMUL : S_DIV) : S_WRITE;
                    case (r_mode)
                        lcg48_pkg::MODE_TOP: begin
                            r_res <= (r_count == '0) ? '0 :
                                     WB'(r_rng >> (6'(SB) - r_count));
                        end
                        lcg48_pkg::MODE_BOOL: r_res <= {31'b0, r_rng[SB-1]};
                        lcg48_pkg::MODE_WORD: r_res <= r_rng[SB-1:SB-WB];
                        lcg48_pkg::MODE_FRAC: begin
                            r_res <= WB'(r_rng[SB-1:SB-lcg48_pkg::FRAC_BITS]);
                        end
                        lcg48_pkg::MODE_BELOW, lcg48_pkg::MODE_RANGE: begin
                            if (r_pow2) begin
                                r_prod <= {{DB{1'b0}}, r_n} * {{DB{1'b0}}, r_rng[SB-1:SB-DB]};
                            end
                        end
                        default: r_res <= '0;
                    endcase
                end
                S_PMUL: begin
                    r_res <= r_lo + {1'b0, r_prod[2*DB-1:DB]};
                    r_st  <= S_WRITE;
                end
                S_DIV: begin
                    if (div_st.done) begin
                        r_st <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (chk[WB-1]) begin
                        r_acc <= lcg48_pkg::LCG_ADD;
                        r_mk  <= 2'd0;
                        r_st  <= S_MUL;
                    end else begin
                        r_res <= r_lo + {1'b0, div_rem};
                        r_st  <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    if (out_free) begin
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
            r_out_value <= r_res;
            r_out_bad   <= r_res_bad;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stall     = r_st != S_IDLE;
    assign o_valid     = r_out_valid;
    assign o_value     = $signed(r_out_value);
    assign o_bad_bound = r_out_bad;

    // the remainder unit must be running or finishing while the sequencer waits on it
    a_div_alive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_DIV) |-> (div_st.busy || div_st.done))
        else $error("sequencer waits on idle remainder unit");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_bound) |-> (o_value == 32'sd0))
        else $error("bad bound result carries a nonzero value");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("request taken without going busy");

endmodule

// File: design/lcg48_divider.sv
// ----------------------------------------------------------------------------
// lcg48_divider
// Serial restoring remainder unit over a 31-bit dividend: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lcg48_divider (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [lcg48_pkg::DRAW_BITS-1:0]     i_dividend,
    input  logic [lcg48_pkg::DRAW_BITS-1:0]     i_divisor,
    output lcg48_pkg::t_div_status              o_status,
    output logic [lcg48_pkg::DRAW_BITS-1:0]     o_rem
);

    localparam int W = lcg48_pkg::DRAW_BITS;
    localparam logic [4:0] LAST = 5'(W - 1);

    logic         r_busy;
    logic         r_done;
    logic [4:0]   r_cnt;
    logic [W-1:0] r_rem;
    logic [W-1:0] r_dvd;
    logic [W-1:0] r_dvs;
    logic [W:0]   trial;
    logic         fits;

    assign trial = {r_rem, r_dvd[W-1]};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_dvd  <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= fits ? W'(trial - {1'b0, r_dvs}) : trial[W-1:0];
                r_dvd <= {r_dvd[W-2:0], 1'b0};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_rem         = r_rem;

endmodule

// File: verif/lcg48_random_source_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg48_random_source_tb
// Self-checking bench for the 48-bit LCG random source. A local predictor
// tracks the generator state and works out every draw: top bits, bool, word,
// bounded and range draws with rejection, fraction and reseed. Results are
// checked in order while the sender idles in bursts and the receiver stalls.
// ----------------------------------------------------------------------------
module lcg48_random_source_tb;

    typedef struct packed {
        logic [31:0] value;
        logic        bad_bound;
    } t_draw;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_valid      = 1'b0;
    logic               o_stall;
    logic [2:0]         i_mode       = lcg48_pkg::MODE_TOP;
    logic [5:0]         i_bit_count  = '0;
    logic signed [31:0] i_bound      = '0;
    logic signed [31:0] i_range_low  = '0;
    logic signed [31:0] i_range_high = '0;
    logic [47:0]        i_seed_value = '0;
    logic               o_valid;
    logic               i_stall      = 1'b0;
    logic signed [31:0] o_value;
    logic               o_bad_bound;

    logic [lcg48_pkg::STATE_BITS-1:0] lcg_state = '0;
    t_draw                 expected_draws[$];
    int unsigned           sent_count    = 0;
    int unsigned           checked_count = 0;
    int unsigned           flagged_count = 0;
    int unsigned           reseed_count  = 0;
    int unsigned           error_count   = 0;
    int unsigned           burst_left    = 0;
    int unsigned           stall_left    = 0;
    bit                    stall_now     = 1'b0;
    bit                    stall_enable  = 1'b1;
    bit                    pace_enable   = 1'b1;

    lcg48_random_source dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_mode       (i_mode),
        .i_bit_count  (i_bit_count),
        .i_bound      (i_bound),
        .i_range_low  (i_range_low),
        .i_range_high (i_range_high),
        .i_seed_value (i_seed_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_value      (o_value),
        .o_bad_bound  (o_bad_bound)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [31:0] draw_top_bits(int unsigned count);
        lcg_state = lcg_state * lcg48_pkg::LCG_MULT + lcg48_pkg::LCG_ADD;
        if (count == 0) return '0;
        if (count > lcg48_pkg::WORD_BITS) count = lcg48_pkg::WORD_BITS;
        return 32'(lcg_state >> (lcg48_pkg::STATE_BITS - count));
    endfunction

    function automatic logic [31:0] draw_below(logic [31:0] n);
        logic [63:0] scaled;
        logic [31:0] bits;
        logic [31:0] rem;
        logic [31:0] wrap_check;
        if ((n & (n - 32'd1)) == '0) begin
            scaled = 64'(n) * 64'(draw_top_bits(lcg48_pkg::DRAW_BITS));
            return scaled[62:31];
        end
        do begin
            bits       = draw_top_bits(lcg48_pkg::DRAW_BITS);
            rem        = bits % n;
            wrap_check = bits - rem + n - 32'd1;
        end while (wrap_check[31]);
        return rem;
    endfunction

    function automatic t_draw predict_draw(logic [2:0] mode, logic [5:0] count,
                                           logic [31:0] bound, logic [31:0] lo,
                                           logic [31:0] hi, logic [47:0] seed);
        t_draw       r;
        logic [31:0] width;
        r = '0;
        case (mode)
            lcg48_pkg::MODE_TOP:    r.value = draw_top_bits(32'(count));
            lcg48_pkg::MODE_BOOL:   r.value = draw_top_bits(1);
            lcg48_pkg::MODE_WORD:   r.value = draw_top_bits(lcg48_pkg::WORD_BITS);
            lcg48_pkg::MODE_BELOW: begin
                if (bound == '0 || bound[31]) r.bad_bound = 1'b1;
                else r.value = draw_below(bound);
            end
            lcg48_pkg::MODE_RANGE: begin
                width = hi - lo;
                if (width == '0 || width[31]) r.bad_bound = 1'b1;
                else r.value = lo + draw_below(width);
            end
            lcg48_pkg::MODE_FRAC:   r.value = draw_top_bits(lcg48_pkg::FRAC_BITS);
            lcg48_pkg::MODE_RESEED: lcg_state = seed;
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [47:0] random_seed();
        logic [15:0] top;
        top = 16'($urandom());
        return {top, $urandom()};
    endfunction

    function automatic logic [31:0] random_bound();
        case ($urandom_range(0, 11))
            0, 1:    return $urandom_range(1, 16);
            2:       return 32'd1 << $urandom_range(0, 30);
            3:       return $urandom_range(32'h4000_0001, 32'h7FFF_FFFF);
            4:       return $urandom_range(1, 32'h7FFF_FFFF);
            5:       return 32'h8000_0000 | $urandom();
            6:       return '0;
            default: return $urandom_range(1, 100000);
        endcase
    endfunction

    task automatic send_request(input logic [2:0] mode, input logic [5:0] count,
                                input logic [31:0] bound, input logic [31:0] lo,
                                input logic [31:0] hi, input logic [47:0] seed);
        int unsigned gap;
        i_valid      <= 1'b1;
        i_mode       <= mode;
        i_bit_count  <= count;
        i_bound      <= bound;
        i_range_low  <= lo;
        i_range_high <= hi;
        i_seed_value <= seed;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        expected_draws.push_back(predict_draw(mode, count, bound, lo, hi, seed));
        sent_count++;
        if (mode == lcg48_pkg::MODE_RESEED) reseed_count++;
        if (!pace_enable) return;
        if (burst_left != 0) begin
            burst_left--;
            return;
        end
        i_valid <= 1'b0;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 5);
        repeat (gap) @(posedge i_clk);
        burst_left = $urandom_range(0, 12);
    endtask

    task automatic send_random_request();
        logic [2:0]  mode;
        logic [5:0]  count;
        logic [31:0] lo;
        logic [31:0] hi;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)      mode = lcg48_pkg::MODE_TOP;
        else if (pick < 18) mode = lcg48_pkg::MODE_BOOL;
        else if (pick < 28) mode = lcg48_pkg::MODE_WORD;
        else if (pick < 55) mode = lcg48_pkg::MODE_BELOW;
        else if (pick < 82) mode = lcg48_pkg::MODE_RANGE;
        else if (pick < 92) mode = lcg48_pkg::MODE_FRAC;
        else if (pick < 98) mode = lcg48_pkg::MODE_RESEED;
        else                mode = lcg48_pkg::MODE_UNUSED;
        count = ($urandom_range(0, 7) == 0) ? 6'($urandom()) : 6'($urandom_range(1, 32));
        lo    = $urandom;
        hi    = ($urandom_range(0, 3) == 0) ? 32'($urandom()) : lo + random_bound();
        send_request(mode, count, random_bound(), lo, hi, random_seed());
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (expected_draws.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed_cases();
        send_request(lcg48_pkg::MODE_TOP, 6'd1, '0, '0, '0, '0);
        send_request(lcg48_pkg::MODE_TOP, 6'd32, '0, '0, '0, '0);
        send_request(lcg48_pkg::MODE_TOP, 6'd0, '0, '0, '0, '0);
        send_request(lcg48_pkg::MODE_TOP, 6'd33, '0, '0, '0, '0);
        send_request(lcg48_pkg::MODE_TOP, 6'd63, '0, '0, '0, '0);
        send_request(lcg48_pkg::MODE_BOOL, '0, '0, '0, '0, '0);
        send_request(lcg48_pkg::MODE_WORD, '0, '0, '0, '0, '0);
        send_request(lcg48_pkg::MODE_FRAC, '0, '0, '0, '0, '0);
        send_request(lcg48_pkg::MODE_BELOW, '0, 32'd1, '0, '0, '0);
        send_request(lcg48_pkg::MODE_BELOW, '0, 32'h4000_0000, '0, '0, '0);
        send_request(lcg48_pkg::MODE_BELOW, '0, 32'h7FFF_FFFF, '0, '0, '0);
        send_request(lcg48_pkg::MODE_BELOW, '0, 32'h4000_0001, '0, '0, '0);
        send_request(lcg48_pkg::MODE_BELOW, '0, 32'd0, '0, '0, '0);
        send_request(lcg48_pkg::MODE_BELOW, '0, 32'hFFFF_FFFF, '0, '0, '0);
        send_request(lcg48_pkg::MODE_BELOW, '0, 32'h8000_0000, '0, '0, '0);
        send_request(lcg48_pkg::MODE_RANGE, '0, '0, -32'sd10, 32'sd10, '0);
        send_request(lcg48_pkg::MODE_RANGE, '0, '0, 32'h8000_0000, 32'h7FFF_FFFF, '0);
        send_request(lcg48_pkg::MODE_RANGE, '0, '0, 32'sd5, 32'sd5, '0);
        send_request(lcg48_pkg::MODE_RANGE, '0, '0, 32'hC000_0000, 32'h4000_0000, '0);
        send_request(lcg48_pkg::MODE_RANGE, '0, '0, 32'h8000_0000, 32'hFFFF_FFFF, '0);
        send_request(lcg48_pkg::MODE_RANGE, '0, '0, 32'h7FFF_FFF0, 32'h7FFF_FFF8, '0);
        send_request(lcg48_pkg::MODE_RESEED, '0, '0, '0, '0, 48'hFFFF_FFFF_FFFF);
        send_request(lcg48_pkg::MODE_WORD, '0, '0, '0, '0, '0);
        send_request(lcg48_pkg::MODE_RESEED, '0, '0, '0, '0, 48'h0);
        send_request(lcg48_pkg::MODE_TOP, 6'd32, '0, '0, '0, '0);
        send_request(lcg48_pkg::MODE_UNUSED, 6'd5, 32'd7, 32'd1, 32'd9, 48'h1234);
        send_request(lcg48_pkg::MODE_WORD, '0, '0, '0, '0, '0);
        wait_for_results();
    endtask

    task automatic test_random_mix();
        repeat (350) send_random_request();
        wait_for_results();
    endtask

    task automatic test_power_of_two_bounds();
        logic [31:0] lo;
        for (int k = 0; k <= 30; k++) begin
            lo = $urandom;
            send_request(lcg48_pkg::MODE_BELOW, 6'($urandom()), 32'd1 << k, $urandom,
                         $urandom, random_seed());
            send_request(lcg48_pkg::MODE_RANGE, 6'($urandom()), $urandom, lo,
                         lo + (32'd1 << k), random_seed());
        end
        wait_for_results();
    endtask

    task automatic test_reseed_streams();
        for (int s = 0; s < 12; s++) begin
            stall_enable = (s >= 6);
            pace_enable  = (s >= 6);
            send_request(lcg48_pkg::MODE_RESEED, 6'($urandom()), $urandom, $urandom,
                         $urandom, random_seed());
            repeat (4) send_random_request();
        end
        wait_for_results();
        stall_enable = 1'b1;
        pace_enable  = 1'b1;
    endtask

    // receiver back-pressure: random runs of stall and free cycles
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_now  = ($urandom_range(0, 2) == 0);
            stall_left = stall_now ? $urandom_range(1, ($urandom_range(0, 7) == 0) ? 45 : 6)
                                   : $urandom_range(1, 24);
        end
        stall_left--;
        i_stall <= stall_enable && stall_now;
    end

    always @(posedge i_clk) begin : result_check
        t_draw want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_draws.size() == 0) begin
                $error("unexpected transaction: value %h bad_bound %b", o_value, o_bad_bound);
                error_count++;
            end else begin
                want = expected_draws.pop_front();
                checked_count++;
                if (want.bad_bound) flagged_count++;
                if (o_value !== want.value) begin
                    $error("value: expected %h, actual %h", want.value, o_value);
                    error_count++;
                end
                if (o_bad_bound !== want.bad_bound) begin
                    $error("bad_bound: expected %b, actual %b", want.bad_bound, o_bad_bound);
                    error_count++;
                end
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_random_mix();
        test_power_of_two_bounds();
        test_reseed_streams();
        wait_for_results();
        repeat (100) @(posedge i_clk);
        if (expected_draws.size() != 0) error_count++;
        $display("covered %0d requests over all modes, %0d results compared",
                 sent_count, checked_count);
        $display("%0d draws flagged as bad bounds, %0d reseeds", flagged_count, reseed_count);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
